@@ rtl/core/hto_pkg.sv @@
// Package for the overflow-chained hash table: request/result structs,
// request and outcome codes, default sizes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hto_pkg;

  localparam int KEY_W     = 31;
  localparam int PAY_W     = 32;
  localparam int REQ_W     = 2;
  localparam int OUTCOME_W = 3;
  localparam int SLOT_W    = 3;

  localparam int HOME_SLOTS_DEF     = 4;
  localparam int OVERFLOW_SLOTS_DEF = 3;
  localparam int PAYLOAD_BITS_DEF   = 32;

  // Request codes; the unused code is served as a search
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_FOUND    = 3'd0,
    OUT_FREE     = 3'd1,
    OUT_FULL     = 3'd2,
    OUT_INSERTED = 3'd3,
    OUT_DUP      = 3'd4,
    OUT_REMOVED  = 3'd5,
    OUT_RMISS    = 3'd6
  } outcome_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [SLOT_W-1:0]    slot;
  } out_item_t;

endpackage : hto_pkg

`default_nettype wire

@@ rtl/core/hash_table_overflow_chain.sv @@
// Hash table with a separate overflow area chained from each home slot.
// Top level; depends on hto_pkg.
`timescale 1ns / 1ps
`default_nettype none

// A request (search, insert or remove) is taken when start is high and busy
// is low; busy then stays high until the single result has been issued.
// The result sits on out_item for exactly one cycle with out_strobe high and
// cannot be held off, so the receiver must take it in that cycle. A request
// tests the home slot, walks the chain link by link through the key/link
// store read port, probes the overflow slots one at a time in the free-slot
// scan, commits, and then issues the registered result strobe. A removed
// chain head that takes over its successor goes through an extra copy step,
// but that path never scans. When HOME_SLOTS is not a power of two the home
// slot is worked out first by a 4-bit-per-cycle remainder unit. The store is
// empty after reset, with no clearing pass; the slot field carries the low
// 3 bits of the slot number and is 0 for a full table or a remove miss.
module hash_table_overflow_chain
  import hto_pkg::*;
#(
  parameter int HOME_SLOTS     = HOME_SLOTS_DEF,
  parameter int OVERFLOW_SLOTS = OVERFLOW_SLOTS_DEF,
  parameter int PAYLOAD_BITS   = PAYLOAD_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_strobe,
  output out_item_t      out_item
);

  localparam int TOTAL = HOME_SLOTS + OVERFLOW_SLOTS;
  localparam int IW    = $clog2(TOTAL);          // slot index
  localparam int LW    = $clog2(TOTAL + 1);      // link, can hold "none"
  localparam int HW    = $clog2(HOME_SLOTS);     // home index / remainder
  localparam int CW    = (LW > 3) ? LW : 3;      // shared step counter
  localparam bit HOME_POW2 = (HOME_SLOTS & (HOME_SLOTS - 1)) == 0;

  localparam int MOD_BITS  = 4;                  // key bits per cycle
  localparam int KSH_W     = 32;                 // key padded to 8 digits
  localparam int MOD_ITERS = KSH_W / MOD_BITS;

  localparam logic [LW-1:0] LINK_NONE = LW'(TOTAL);
  localparam logic [IW-1:0] FIRST_OVF = IW'(HOME_SLOTS);
  localparam logic [IW-1:0] LAST_SLOT = IW'(TOTAL - 1);
  localparam logic [HW:0]   HOME_CMP  = (HW + 1)'(HOME_SLOTS);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MOD  = 7'b0000010,   // key mod HOME_SLOTS, non power-of-two only
    S_HOME = 7'b0000100,   // test home slot, start first read
    S_WALK = 7'b0001000,   // one chain link per cycle
    S_SCAN = 7'b0010000,   // probe overflow slots for a free one
    S_ACT  = 7'b0100000,   // commit request
    S_COPY = 7'b1000000    // head removal: pull successor into head
  } state_t;

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  state_t                  state_r, state_nxt;
  logic [REQ_W-1:0]        req_r, req_nxt;
  logic [KEY_W-1:0]        key_r, key_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;
  logic [IW-1:0]           home_r, home_nxt;
  logic [HW-1:0]           rem_r, rem_nxt;
  logic [KSH_W-1:0]        kshift_r, kshift_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [IW-1:0]           cur_r, cur_nxt;
  logic [LW-1:0]           prev_r, prev_nxt;   // predecessor of found slot
  logic [IW-1:0]           tail_r, tail_nxt;   // last slot walked
  logic [LW-1:0]           succ_r, succ_nxt;   // link of found slot
  outcome_t                lk_out_r, lk_out_nxt;
  logic [IW-1:0]           lk_slot_r, lk_slot_nxt;

  logic [TOTAL-1:0]        valid_r, valid_nxt;
  logic [TOTAL-1:0]        link_set_r, link_set_nxt;  // clear: link is none

  logic                    out_strobe_r, out_strobe_nxt;
  out_item_t               out_item_r, out_item_nxt;

  // ---------------------------------------------------------------------
  // Stores: one read address, registered read data, one write per store
  // ---------------------------------------------------------------------
  logic [KEY_W-1:0]        key_mem  [TOTAL];
  logic [PAYLOAD_BITS-1:0] pay_mem  [TOTAL];
  logic [LW-1:0]           link_mem [TOTAL];

  logic [IW-1:0]           rd_addr;
  logic [KEY_W-1:0]        key_rd_r;
  logic [PAYLOAD_BITS-1:0] pay_rd_r;
  logic [LW-1:0]           link_rd_r;
  logic                    link_set_rd_r;

  logic                    kp_we;
  logic [IW-1:0]           kp_addr;
  logic [KEY_W-1:0]        key_wdata;
  logic [PAYLOAD_BITS-1:0] pay_wdata;

  logic                    lnk_we;
  logic [IW-1:0]           lnk_waddr;
  logic [LW-1:0]           lnk_wdata;

  logic [LW-1:0]           link_val;   // link of the slot just read
  logic [HW:0]             mod_t;
  logic [HW-1:0]           mod_w;

  assign link_val = link_set_rd_r ? link_rd_r : LINK_NONE;

  always_ff @(posedge clk) begin
    if (kp_we) begin
      key_mem[kp_addr] <= key_wdata;
      pay_mem[kp_addr] <= pay_wdata;
    end
    if (lnk_we) begin
      link_mem[lnk_waddr] <= lnk_wdata;
    end
    key_rd_r      <= key_mem[rd_addr];
    pay_rd_r      <= pay_mem[rd_addr];
    link_rd_r     <= link_mem[rd_addr];
    link_set_rd_r <= link_set_r[rd_addr];
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    key_nxt        = key_r;
    pay_nxt        = pay_r;
    home_nxt       = home_r;
    rem_nxt        = rem_r;
    kshift_nxt     = kshift_r;
    cnt_nxt        = cnt_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    tail_nxt       = tail_r;
    succ_nxt       = succ_r;
    lk_out_nxt     = lk_out_r;
    lk_slot_nxt    = lk_slot_r;
    valid_nxt      = valid_r;
    link_set_nxt   = link_set_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    rd_addr        = cur_r;
    kp_we          = 1'b0;
    kp_addr        = lk_slot_r;
    key_wdata      = key_r;
    pay_wdata      = pay_r;
    lnk_we         = 1'b0;
    lnk_waddr      = tail_r;
    lnk_wdata      = LW'(lk_slot_r);
    mod_t          = '0;
    mod_w          = rem_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt    = in_item.req_type;
          key_nxt    = in_item.key;
          pay_nxt    = PAYLOAD_BITS'(in_item.payload);
          kshift_nxt = KSH_W'(in_item.key);
          rem_nxt    = '0;
          cnt_nxt    = '0;
          if (HOME_POW2) begin
            home_nxt  = IW'(in_item.key[HW-1:0]);
            state_nxt = S_HOME;
          end else begin
            state_nxt = S_MOD;
          end
        end
      end

      S_MOD: begin
        // restoring remainder, MSB first, four key bits a cycle
        for (int j = 0; j < MOD_BITS; j++) begin
          mod_t = {mod_w, kshift_r[KSH_W-1-j]};
          if (mod_t >= HOME_CMP) begin
            mod_t = mod_t - HOME_CMP;
          end
          mod_w = mod_t[HW-1:0];
        end
        rem_nxt    = mod_w;
        kshift_nxt = kshift_r << MOD_BITS;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CW'(MOD_ITERS - 1)) begin
          home_nxt  = IW'(mod_w);
          cnt_nxt   = '0;
          state_nxt = S_HOME;
        end
      end

      S_HOME: begin
        prev_nxt    = LINK_NONE;
        tail_nxt    = home_r;
        lk_slot_nxt = home_r;
        if (!valid_r[home_r]) begin
          lk_out_nxt = OUT_FREE;
          state_nxt  = S_ACT;
        end else begin
          rd_addr   = home_r;
          cur_nxt   = home_r;
          cnt_nxt   = '0;
          state_nxt = S_WALK;
        end
      end

      S_WALK: begin
        if (valid_r[cur_r] && key_rd_r == key_r) begin
          lk_out_nxt  = OUT_FOUND;
          lk_slot_nxt = cur_r;
          succ_nxt    = link_val;
          state_nxt   = S_ACT;
        end else begin
          tail_nxt = cur_r;
          if (link_val == LINK_NONE || cnt_r == CW'(TOTAL - 1)) begin
            cur_nxt   = FIRST_OVF;
            state_nxt = S_SCAN;
          end else begin
            prev_nxt = LW'(cur_r);
            cur_nxt  = link_val[IW-1:0];
            rd_addr  = link_val[IW-1:0];
            cnt_nxt  = cnt_r + 1'b1;
          end
        end
      end

      S_SCAN: begin
        if (!valid_r[cur_r]) begin
          lk_out_nxt  = OUT_FREE;
          lk_slot_nxt = cur_r;
          state_nxt   = S_ACT;
        end else if (cur_r == LAST_SLOT) begin
          lk_out_nxt  = OUT_FULL;
          lk_slot_nxt = '0;
          state_nxt   = S_ACT;
        end else begin
          cur_nxt = cur_r + 1'b1;
        end
      end

      S_ACT: begin
        out_item_nxt.outcome = lk_out_r;
        out_item_nxt.slot    = SLOT_W'(lk_slot_r);
        out_strobe_nxt       = 1'b1;
        state_nxt            = S_IDLE;
        priority if (req_r == REQ_INSERT) begin
          if (lk_out_r == OUT_FOUND) begin
            out_item_nxt.outcome = OUT_DUP;
          end else if (lk_out_r == OUT_FREE) begin
            kp_we                   = 1'b1;
            valid_nxt[lk_slot_r]    = 1'b1;
            link_set_nxt[lk_slot_r] = 1'b0;
            if (lk_slot_r != home_r) begin
              // append to chain tail
              lnk_we               = 1'b1;
              link_set_nxt[tail_r] = 1'b1;
            end
            out_item_nxt.outcome = OUT_INSERTED;
          end
        end else if (req_r == REQ_REMOVE) begin
          if (lk_out_r != OUT_FOUND) begin
            out_item_nxt.outcome = OUT_RMISS;
            out_item_nxt.slot    = '0;
          end else if (prev_r == LINK_NONE) begin
            if (succ_r != LINK_NONE && succ_r != LW'(lk_slot_r)) begin
              // head with successor: fetch successor, result after copy
              rd_addr        = succ_r[IW-1:0];
              out_strobe_nxt = 1'b0;
              state_nxt      = S_COPY;
            end else begin
              valid_nxt[lk_slot_r] = 1'b0;
              out_item_nxt.outcome = OUT_REMOVED;
            end
          end else begin
            // bridge predecessor over the removed entry
            valid_nxt[lk_slot_r] = 1'b0;
            if (succ_r != LINK_NONE) begin
              lnk_we                          = 1'b1;
              lnk_waddr                       = prev_r[IW-1:0];
              lnk_wdata                       = succ_r;
              link_set_nxt[prev_r[IW-1:0]]    = 1'b1;
            end else begin
              link_set_nxt[prev_r[IW-1:0]]    = 1'b0;
            end
            link_set_nxt[lk_slot_r] = 1'b0;
            out_item_nxt.outcome    = OUT_REMOVED;
          end
        end else begin
          if (lk_out_r == OUT_FULL) begin
            out_item_nxt.slot = '0;
          end
        end
      end

      S_COPY: begin
        kp_we     = 1'b1;
        key_wdata = key_rd_r;
        pay_wdata = pay_rd_r;
        if (link_val != LINK_NONE) begin
          lnk_we                  = 1'b1;
          lnk_waddr               = lk_slot_r;
          lnk_wdata               = link_val;
          link_set_nxt[lk_slot_r] = 1'b1;
        end else begin
          link_set_nxt[lk_slot_r] = 1'b0;
        end
        valid_nxt[lk_slot_r]          = 1'b1;
        valid_nxt[succ_r[IW-1:0]]     = 1'b0;
        link_set_nxt[succ_r[IW-1:0]]  = 1'b0;
        out_item_nxt.outcome = OUT_REMOVED;
        out_item_nxt.slot    = SLOT_W'(lk_slot_r);
        out_strobe_nxt       = 1'b1;
        state_nxt            = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      link_set_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      link_set_r   <= link_set_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    key_r      <= key_nxt;
    pay_r      <= pay_nxt;
    home_r     <= home_nxt;
    rem_r      <= rem_nxt;
    kshift_r   <= kshift_nxt;
    cnt_r      <= cnt_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    tail_r     <= tail_nxt;
    succ_r     <= succ_nxt;
    lk_out_r   <= lk_out_nxt;
    lk_slot_r  <= lk_slot_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // a result is only issued once the sequencer is back in idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result issued while busy");

  // an accepted request always occupies the sequencer next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but not started");

  // an insert result leaves its slot marked occupied
  a_insert_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.outcome == OUT_INSERTED) |-> valid_r[lk_slot_r])
    else $error("inserted slot not valid");

  // store writes happen only in the commit or copy steps
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (kp_we || lnk_we) |-> (state_r == S_ACT || state_r == S_COPY))
    else $error("store written outside commit");

endmodule : hash_table_overflow_chain

`default_nettype wire

@@ bench/tb_hash_table_overflow_chain.sv @@
// Self-checking bench for hash_table_overflow_chain: queue-fed request driver,
// result monitor with an in-bench table predictor, stall watchdog.
// Depends on hto_pkg and the hash_table_overflow_chain RTL only.
`timescale 1ns / 1ps

module tb_hash_table_overflow_chain;
  import hto_pkg::*;

  // Table geometry, as the block is built with its default sizes
  localparam int HOME_N      = HOME_SLOTS_DEF;
  localparam int SLOTS_N     = HOME_SLOTS_DEF + OVERFLOW_SLOTS_DEF;
  localparam int LINK_NONE   = SLOTS_N;
  localparam int STALL_LIMIT = 1000;  // cycles with no request or result taken
  localparam int DRAIN_WAIT  = 20;    // settle wait after the last result is back
  localparam int PHASES      = 8;
  localparam int PHASE_REQS  = 150;

  // One queued request: the item, idle cycles before it, and whether the
  // driver must wait for every outstanding result before presenting it
  typedef struct packed {
    in_item_t   item;
    logic [7:0] gap;
    logic       drain;
  } pend_req_t;

  // Outcome of walking a key's chain
  typedef struct packed {
    outcome_t outcome;
    int       slot;
    int       prev;   // predecessor of the hit, LINK_NONE when it is the head
    int       tail;   // last slot visited on the chain
  } chain_probe_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_strobe;
  out_item_t out_item;

  // Predicted table contents
  logic [KEY_W-1:0] tbl_key [SLOTS_N];
  logic [PAY_W-1:0] tbl_pay [SLOTS_N];
  int               tbl_link[SLOTS_N];
  logic             tbl_used[SLOTS_N];

  pend_req_t pending_q[$];
  out_item_t expected_q[$];
  pend_req_t next_req;
  bit        have_next = 1'b0;
  int        gap_left = 0;
  int        issued_cnt = 0;  // requests taken by the block (driver side)
  int        done_cnt = 0;    // results seen (monitor side, nonblocking)
  int        err_cnt = 0;
  int        stall_cycles = 0;
  int        clr_idx;
  out_item_t want_res;

  hash_table_overflow_chain u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Walk the chain from the key's home slot. An empty home answers at once.
  // On a miss the lowest free overflow slot is offered, else the table is full.
  function automatic chain_probe_t probe_chain(logic [KEY_W-1:0] key);
    chain_probe_t pr;
    int home, cur, prior, nxt, step, i;
    bit hit, stop;
    home = int'(key % HOME_N);
    cur = home;
    prior = LINK_NONE;
    hit = 1'b0;
    stop = 1'b0;
    pr.outcome = OUT_FREE;
    pr.slot = home;
    pr.prev = LINK_NONE;
    pr.tail = home;
    if (!tbl_used[home]) return pr;
    for (step = 0; step < SLOTS_N && !hit && !stop; step++) begin
      if (tbl_used[cur] && tbl_key[cur] == key) begin
        hit = 1'b1;
        pr.outcome = OUT_FOUND;
        pr.slot = cur;
        pr.prev = prior;
      end else begin
        pr.tail = cur;
        nxt = tbl_link[cur];
        // a link past the table ends the chain
        if (nxt >= SLOTS_N) begin
          stop = 1'b1;
        end else begin
          prior = cur;
          cur = nxt;
        end
      end
    end
    if (!hit) begin
      pr.outcome = OUT_FULL;
      pr.slot = 0;
      // scan downwards so the lowest free slot is the one left standing
      for (i = SLOTS_N - 1; i >= HOME_N; i--) begin
        if (!tbl_used[i]) begin
          pr.outcome = OUT_FREE;
          pr.slot = i;
        end
      end
    end
    return pr;
  endfunction

  // Apply one request to the predicted table and return the expected result
  function automatic out_item_t apply_table_req(in_item_t req);
    chain_probe_t pr;
    out_item_t    res;
    int           home, nxt;
    pr = probe_chain(req.key);
    home = int'(req.key % HOME_N);
    res.outcome = pr.outcome;
    res.slot = SLOT_W'(pr.slot);
    case (req.req_type)
      REQ_INSERT: begin
        if (pr.outcome == OUT_FOUND) begin
          res.outcome = OUT_DUP;
        end else if (pr.outcome == OUT_FREE) begin
          // PAYLOAD_BITS equals the port width, so no masking is needed
          tbl_key[pr.slot] = req.key;
          tbl_pay[pr.slot] = req.payload;
          tbl_link[pr.slot] = LINK_NONE;
          tbl_used[pr.slot] = 1'b1;
          if (pr.slot != home) tbl_link[pr.tail] = pr.slot;
          res.outcome = OUT_INSERTED;
        end
      end
      REQ_REMOVE: begin
        if (pr.outcome != OUT_FOUND) begin
          res.outcome = OUT_RMISS;
          res.slot = '0;
        end else begin
          nxt = tbl_link[pr.slot];
          tbl_used[pr.slot] = 1'b0;
          if (pr.prev >= SLOTS_N) begin
            // head: pull the successor forward and free its slot
            if (nxt < SLOTS_N && nxt != pr.slot) begin
              tbl_key[pr.slot] = tbl_key[nxt];
              tbl_pay[pr.slot] = tbl_pay[nxt];
              tbl_link[pr.slot] = tbl_link[nxt];
              tbl_used[pr.slot] = 1'b1;
              tbl_used[nxt] = 1'b0;
              tbl_link[nxt] = LINK_NONE;
            end
          end else begin
            tbl_link[pr.prev] = nxt;
            tbl_link[pr.slot] = LINK_NONE;
          end
          res.outcome = OUT_REMOVED;
        end
      end
      default: ;  // search, and the spare code served as a search
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present queued requests, honouring gaps and drain points; predict
  // each request at the edge where the block takes it
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      for (clr_idx = 0; clr_idx < SLOTS_N; clr_idx++) begin
        tbl_used[clr_idx] = 1'b0;
        tbl_link[clr_idx] = LINK_NONE;
      end
    end else begin
      if (start && !busy) begin
        expected_q.push_back(apply_table_req(in_item));
        issued_cnt++;
      end
      // channel is free once the last request went in, or none is up
      if (!start || !busy) begin
        if (!have_next && pending_q.size() != 0) begin
          next_req = pending_q.pop_front();
          have_next = 1'b1;
          gap_left = next_req.gap;
        end
        if (have_next && gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (have_next && next_req.drain &&
                     (issued_cnt != done_cnt || (start && !busy))) begin
          start <= 1'b0;  // hold off until everything outstanding is back
        end else if (have_next) begin
          in_item <= next_req.item;
          start <= 1'b1;
          have_next = 1'b0;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result is checked against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with no request outstanding: outcome %0d slot %0d",
                 $time, out_item.outcome, out_item.slot);
        err_cnt++;
      end else begin
        want_res = expected_q.pop_front();
        if (out_item.outcome !== want_res.outcome) begin
          $display("%0t: outcome mismatch: expected %0d, actual %0d",
                   $time, want_res.outcome, out_item.outcome);
          err_cnt++;
        end
        if (out_item.slot !== want_res.slot) begin
          $display("%0t: slot mismatch: expected %0d, actual %0d",
                   $time, want_res.slot, out_item.slot);
          err_cnt++;
        end
      end
      done_cnt <= done_cnt + 1;
    end
  end

  // Watchdog: ends a hung run
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("hash_table_overflow_chain regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic logic [7:0] pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 8'd0;
    if (r < 90) return 8'($urandom_range(1, 3));
    return 8'($urandom_range(8, 40));
  endfunction

  task automatic add_req(logic [REQ_W-1:0] rtype, logic [KEY_W-1:0] key,
                         logic [PAY_W-1:0] pay, logic [7:0] gap, logic drain);
    pend_req_t pr;
    pr.item.req_type = rtype;
    pr.item.key = key;
    pr.item.payload = pay;
    pr.gap = gap;
    pr.drain = drain;
    pending_q.push_back(pr);
  endtask

  initial begin : stim
    logic [KEY_W-1:0] key_pool[8];
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
    logic [REQ_W-1:0] rtype;
    int phase, n, span, r, ins_pct;
    bit no_gaps;

    // Directed: fill home 0 and its whole overflow area, then take it apart
    add_req(REQ_SEARCH, 31'd0, 32'h0, 8'd0, 1'b0);            // empty home
    add_req(REQ_INSERT, 31'd0, 32'h0, 8'd0, 1'b0);            // into home
    add_req(REQ_INSERT, 31'd0, 32'h1234_5678, 8'd1, 1'b0);    // duplicate
    add_req(REQ_SEARCH, 31'd4, 32'h0, 8'd0, 1'b0);            // miss, free overflow
    add_req(REQ_INSERT, 31'd4, 32'hFFFF_FFFF, 8'd0, 1'b0);
    add_req(REQ_INSERT, 31'd8, 32'hA5A5_A5A5, 8'd0, 1'b0);
    add_req(REQ_INSERT, 31'h7FFF_FFFC, 32'h5A5A_5A5A, 8'd0, 1'b0);
    add_req(REQ_INSERT, 31'd16, 32'h0, 8'd0, 1'b1);           // table full
    add_req(REQ_SEARCH, 31'd16, 32'h0, 8'd0, 1'b0);           // full on search
    add_req(REQ_SEARCH, 31'd8, 32'h0, 8'd2, 1'b0);            // hit mid-chain
    add_req(2'd3, 31'h7FFF_FFFC, 32'hFFFF_FFFF, 8'd0, 1'b0);  // spare code
    add_req(REQ_REMOVE, 31'd8, 32'h0, 8'd0, 1'b0);            // mid-chain unlink
    add_req(REQ_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 8'd0, 1'b0);
    add_req(REQ_INSERT, 31'd3, 32'h0000_0001, 8'd0, 1'b0);    // chain off home 3
    add_req(REQ_REMOVE, 31'd0, 32'h0, 8'd0, 1'b0);            // head takes successor
    add_req(REQ_SEARCH, 31'd4, 32'h0, 8'd0, 1'b0);            // now in home 0
    add_req(REQ_REMOVE, 31'd4, 32'h0, 8'd0, 1'b0);
    add_req(REQ_REMOVE, 31'h7FFF_FFFC, 32'h0, 8'd0, 1'b0);    // lone head
    add_req(REQ_REMOVE, 31'h7FFF_FFFC, 32'h0, 8'd0, 1'b0);    // remove miss
    add_req(REQ_REMOVE, 31'd3, 32'h0, 8'd0, 1'b0);            // chain tail
    add_req(REQ_REMOVE, 31'h7FFF_FFFF, 32'h0, 8'd0, 1'b0);
    add_req(REQ_SEARCH, 31'h5555_5555, 32'h0, 8'd0, 1'b0);
    add_req(REQ_INSERT, 31'h2AAA_AAAA, 32'hAAAA_5555, 8'd0, 1'b0);

    // Random phases: a small key pool crowded onto few home slots so chains
    // grow, the overflow area fills and removes hit heads, middles and tails
    for (phase = 0; phase < PHASES; phase++) begin
      span = $urandom_range(1, HOME_N);
      ins_pct = $urandom_range(30, 55);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (n = 0; n < 8; n++) begin
        key = KEY_W'($urandom);
        key[1:0] = 2'($urandom_range(0, span - 1));
        key_pool[n] = key;
      end
      for (n = 0; n < PHASE_REQS; n++) begin
        r = $urandom_range(0, 99);
        if (r < ins_pct) rtype = REQ_INSERT;
        else if (r < ins_pct + 25) rtype = REQ_REMOVE;
        else if (r < 95) rtype = REQ_SEARCH;
        else rtype = 2'd3;
        key = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom)
                                         : key_pool[$urandom_range(0, 7)];
        r = $urandom_range(0, 9);
        pay = (r == 0) ? '0 : (r == 1) ? '1 : PAY_W'($urandom);
        add_req(rtype, key, pay, no_gaps ? 8'd0 : pick_gap(), n == 0);
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // all requests taken, then all results back, then let the block settle
    while (pending_q.size() != 0 || have_next || start) @(posedge clk);
    while (done_cnt < issued_cnt) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("hash_table_overflow_chain regression: pass");
    end else begin
      $display("hash_table_overflow_chain regression: fail");
    end
    $finish;
  end

endmodule
